FILE: hw/rtl/psd_pkg.sv
// Package for the previous-smaller-distance block: widths, stack depth,
// controller state type and the command/status structs between modules.
// No dependencies.
`default_nettype none
package psd_pkg;

  // Stack depth and field widths
  localparam int MAX_LEN  = 1024;
  localparam int ADDR_W   = $clog2(MAX_LEN);
  localparam int CNT_W    = $clog2(MAX_LEN + 1);
  localparam int POS_W    = ADDR_W;
  localparam int HEIGHT_W = 16;
  localparam int SPAN_W   = 11;
  localparam int ENTRY_W  = HEIGHT_W + POS_W;

  // Controller states
  typedef enum logic [1:0] {
    PSD_IDLE,
    PSD_CHECK,
    PSD_FETCH
  } psd_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;    // latch the incoming bar
    logic pop;     // drop the top entry, load the one below
    logic finish;  // produce the result, push the bar if not full, advance position
  } psd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop_needed;  // stack non-empty and top strictly taller than the bar
    logic out_free;    // output register can take a result this cycle
  } psd_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/psd_if.sv
// Channel interfaces: bar requests in, span results out.
// Depends on psd_pkg.
`default_nettype none
interface psd_in_if;
  logic                        valid;
  logic                        ready;
  logic [psd_pkg::HEIGHT_W-1:0] height;
  logic                        last;

  modport source (output valid, output height, output last, input ready);
  modport sink   (input valid, input height, input last, output ready);
endinterface

interface psd_out_if;
  logic                      valid;
  logic                      ready;
  logic [psd_pkg::SPAN_W-1:0] span;
  logic                      too_long;

  modport source (output valid, output span, output too_long, input ready);
  modport sink   (input valid, input span, input too_long, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/previous_smaller_distance_core.sv
// Previous-smaller-distance core: one span result per bar request.
// An accepted bar is latched; stack entries taller than it are then popped
// one at a time, each pop followed by a fetch state; the result is registered
// once the output register is free. No new bar is taken until the last is done.
// Reset (rst, synchronous): empties the stack, clears position and flags;
// the stack memory is not cleared and needs no clearing pass.
`default_nettype none
module previous_smaller_distance_core (
  input  wire logic clk,
  input  wire logic rst,
  psd_in_if.sink    bars,
  psd_out_if.source spans
);

  psd_pkg::psd_cmd_t    cmd;
  psd_pkg::psd_status_t status;

  psd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bars.valid),
    .in_ready (bars.ready),
    .status   (status),
    .cmd      (cmd)
  );

  psd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_height    (bars.height),
    .in_last      (bars.last),
    .out_valid    (spans.valid),
    .out_ready    (spans.ready),
    .out_span     (spans.span),
    .out_too_long (spans.too_long)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/psd_ctrl.sv
// Controller for the previous-smaller-distance block: sequences accept,
// pop loop and finish. Depends on psd_pkg.
`default_nettype none
module psd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire psd_pkg::psd_status_t status,
  output psd_pkg::psd_cmd_t         cmd
);

  psd_pkg::psd_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psd_pkg::PSD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      psd_pkg::PSD_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = psd_pkg::PSD_CHECK;
        end
      end
      psd_pkg::PSD_CHECK: begin
        if (status.pop_needed) begin
          cmd.pop    = 1'b1;
          state_next = psd_pkg::PSD_FETCH;
        end else if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = psd_pkg::PSD_IDLE;
        end
      end
      psd_pkg::PSD_FETCH: begin
        // wait for the entry below the new top to be read
        state_next = psd_pkg::PSD_CHECK;
      end
      default: begin
        state_next = psd_pkg::PSD_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/psd_datapath.sv
// Datapath for the previous-smaller-distance block: cached stack top,
// stack memory, position counter, span arithmetic and output register.
// Depends on psd_pkg.
`default_nettype none
module psd_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire psd_pkg::psd_cmd_t            cmd,
  output psd_pkg::psd_status_t              status,
  input  wire logic [psd_pkg::HEIGHT_W-1:0] in_height,
  input  wire logic                         in_last,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [psd_pkg::SPAN_W-1:0]        out_span,
  output logic                              out_too_long
);

  localparam logic [psd_pkg::CNT_W-1:0] FULL = psd_pkg::CNT_W'(psd_pkg::MAX_LEN);
  localparam logic [psd_pkg::POS_W-1:0] POS_TOP = psd_pkg::POS_W'(psd_pkg::MAX_LEN - 1);

  // Entries below the top of stack; the top itself is cached in registers
  logic [psd_pkg::ENTRY_W-1:0]  mem [psd_pkg::MAX_LEN];
  logic [psd_pkg::ENTRY_W-1:0]  rd_data;

  logic [psd_pkg::HEIGHT_W-1:0] height;
  logic                         last;
  logic [psd_pkg::HEIGHT_W-1:0] top_h;
  logic [psd_pkg::POS_W-1:0]    top_p;
  logic [psd_pkg::CNT_W-1:0]    count;
  logic [psd_pkg::POS_W-1:0]    position;
  logic                         overflowed;

  logic [psd_pkg::CNT_W-1:0]    rd_idx;
  logic [psd_pkg::CNT_W-1:0]    wr_idx;
  logic [psd_pkg::SPAN_W-1:0]   span_raw;
  logic [psd_pkg::SPAN_W-1:0]   span_next;
  logic                         push;

  assign rd_idx = count - psd_pkg::CNT_W'(2);
  assign wr_idx = count - psd_pkg::CNT_W'(1);
  assign push   = cmd.finish && (count != FULL);

  // Stack memory: registered read of the entry below the top
  always_ff @(posedge clk) begin
    if (push && (count != '0)) begin
      mem[wr_idx[psd_pkg::ADDR_W-1:0]] <= {top_h, top_p};
    end
    rd_data <= mem[rd_idx[psd_pkg::ADDR_W-1:0]];
  end

  // Status towards the controller
  always_comb begin
    status.pop_needed = (count != '0) && (top_h > height);
    status.out_free   = !out_valid || out_ready;
  end

  // Distance back to the nearest bar that is not taller
  always_comb begin
    if (count == '0) begin
      span_raw = psd_pkg::SPAN_W'(position) + psd_pkg::SPAN_W'(1);
    end else if (top_p <= position) begin
      span_raw = psd_pkg::SPAN_W'(position - top_p);
    end else begin
      span_raw = '0;
    end
    span_next = (span_raw == '0) ? psd_pkg::SPAN_W'(1) : span_raw;
  end

  // Latch the bar
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      height <= in_height;
      last   <= in_last;
    end
  end

  // Stack top, count, position
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      position   <= '0;
      overflowed <= 1'b0;
    end else if (cmd.pop) begin
      count <= count - psd_pkg::CNT_W'(1);
      top_h <= rd_data[psd_pkg::ENTRY_W-1 -: psd_pkg::HEIGHT_W];
      top_p <= rd_data[psd_pkg::POS_W-1:0];
    end else if (cmd.finish) begin
      if (push) begin
        count <= count + psd_pkg::CNT_W'(1);
        top_h <= height;
        top_p <= position;
      end
      if (position < POS_TOP) begin
        position <= position + psd_pkg::POS_W'(1);
      end else begin
        overflowed <= 1'b1;
      end
      // end of sequence: start afresh
      if (last) begin
        count      <= '0;
        position   <= '0;
        overflowed <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_span     <= span_next;
      out_too_long <= overflowed;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/psd_checker.sv
// Port-level checks for the previous-smaller-distance core, bound to the
// top level. Depends on psd_pkg.
`default_nettype none
module psd_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [psd_pkg::SPAN_W-1:0] out_span
);

  logic [1:0] pending;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  // Track requests accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_take) - 2'(out_take);
    end
  end

  // A result held back stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Every result belongs to an accepted request
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result without an outstanding request");

  // One bar at a time: no accept on the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_take |=> !in_ready)
    else $error("request accepted while the previous one is in flight");

  // A span is never zero
  a_span_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_span != '0)
    else $error("zero span reported");

endmodule

bind previous_smaller_distance_core psd_checker u_psd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (bars.valid),
  .in_ready  (bars.ready),
  .out_valid (spans.valid),
  .out_ready (spans.ready),
  .out_span  (spans.span)
);
`default_nettype wire
